// ----- hw/rtl/pps_pkg.sv -----
package pps_pkg;

    localparam int NUM_PINS = 3;
    localparam int PIN_IDX_W = 5;
    localparam int SCALE_W = 10;
    localparam int COUNT_W = 18;
    localparam int ADDR_W = 16;
    localparam int WORD_W = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

    localparam logic [7:0] OPC_HALT       = 8'h00;
    localparam logic [7:0] OPC_SHUTDOWN   = 8'h01;
    localparam logic [7:0] OPC_DELAY      = 8'h02;
    localparam logic [7:0] OPC_PIN_ON     = 8'h03;
    localparam logic [7:0] OPC_PIN_OFF    = 8'h04;
    localparam logic [7:0] OPC_PIN_TOGGLE = 8'h05;
    localparam logic [7:0] OPC_TELEMETRY  = 8'h06;
    localparam logic [7:0] OPC_JUMP       = 8'h07;
    localparam logic [7:0] OPC_HALT_ALT   = 8'hFF;

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_TICK  = 2'd1,
        OP_KILL  = 2'd2,
        OP_PAUSE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_HALT = 2'd1,
        ST_ERR  = 2'd2,
        ST_WAIT = 2'd3
    } t_status;

    typedef logic [NUM_PINS-1:0] t_pins;

    typedef struct packed {
        logic [ADDR_W-1:0]  program_pointer;
        logic [ADDR_W-1:0]  shutdown_pointer;
        t_pins              pins;
        logic [COUNT_W-1:0] delay_count;
        logic               waiting;
        logic               halted;
        logic               kill_pending;
        logic               pause_pending;
        logic               running_lamp;
    } t_state;

    localparam t_state STATE_RESET = '{
        program_pointer:  '0,
        shutdown_pointer: '0,
        pins:             '0,
        delay_count:      '0,
        waiting:          1'b0,
        halted:           1'b0,
        kill_pending:     1'b0,
        pause_pending:    1'b0,
        running_lamp:     1'b1
    };

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] fetch_address;
        t_pins             pin_levels;
        logic              run_light;
        logic              telemetry_valid;
        logic [ADDR_W-1:0] telemetry_pointer;
        logic [ADDR_W-1:0] telemetry_shutdown;
    } t_result;

endpackage

// ----- hw/rtl/pin_program_sequencer.sv -----
// Pin program sequencer. Each accepted input word is either a program word to
// execute (operation 0) or a tick, kill or pause event, and gives exactly one
// result word in the next cycle. One word is accepted every cycle while the
// result register is empty or being drained; the limit is the single state
// register that each word updates. delay_scale is written through the
// configuration channel, which is always ready; write it only while idle.
module pin_program_sequencer
    import pps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SCALE_W-1:0]  i_cfg_delay_scale,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_operation,
    input  logic [WORD_W-1:0]   i_instruction_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [ADDR_W-1:0]   o_fetch_address,
    output logic [NUM_PINS-1:0] o_pin_levels,
    output logic                o_run_light,
    output logic                o_telemetry_valid,
    output logic [ADDR_W-1:0]   o_telemetry_pointer,
    output logic [ADDR_W-1:0]   o_telemetry_shutdown
);

    logic [SCALE_W-1:0] r_scale;
    t_state             r_state;
    t_state             n_state;
    t_result            step_result;
    t_result            out_result;
    logic               space;
    logic               accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = space;
    assign accept      = i_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_delay_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    pps_step u_step (
        .i_state  (r_state),
        .i_op     (t_op'(i_operation)),
        .i_word   (i_instruction_word),
        .i_scale  (r_scale),
        .o_state  (n_state),
        .o_result (step_result)
    );

    pps_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (i_valid),
        .i_result (step_result),
        .i_take   (i_ready),
        .o_space  (space),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_status             = out_result.status;
    assign o_fetch_address      = out_result.fetch_address;
    assign o_pin_levels         = out_result.pin_levels;
    assign o_run_light          = out_result.run_light;
    assign o_telemetry_valid    = out_result.telemetry_valid;
    assign o_telemetry_pointer  = out_result.telemetry_pointer;
    assign o_telemetry_shutdown = out_result.telemetry_shutdown;

endmodule

// ----- hw/rtl/pps_step.sv -----
module pps_step
    import pps_pkg::*;
(
    input  t_state             i_state,
    input  t_op                i_op,
    input  logic [WORD_W-1:0]  i_word,
    input  logic [SCALE_W-1:0] i_scale,
    output t_state             o_state,
    output t_result            o_result
);

    logic [7:0]           opc;
    logic [7:0]           opnd;
    logic [PIN_IDX_W-1:0] pin;
    logic                 pin_ok;
    t_pins                pin_bit;
    logic [COUNT_W-1:0]   product;
    logic [COUNT_W-1:0]   count_dec;
    logic [ADDR_W-1:0]    pp_inc;
    t_state               n;
    t_result              r;

    assign opc       = i_word[15:8];
    assign opnd      = i_word[7:0];
    assign pin       = opnd[PIN_IDX_W-1:0];
    assign pin_ok    = {1'b0, pin} < (PIN_IDX_W+1)'(NUM_PINS);
    assign pin_bit   = t_pins'(1) << pin;
    assign product   = {{(COUNT_W-8){1'b0}}, opnd} * {{(COUNT_W-SCALE_W){1'b0}}, i_scale};
    assign count_dec = i_state.delay_count - COUNT_W'(1);
    assign pp_inc    = i_state.program_pointer + ADDR_W'(1);

    always_comb begin
        n = i_state;
        r = '0;
        r.status = ST_OK;
        if (i_state.halted) begin
            r.status = ST_HALT;
        end else begin
            unique case (i_op)
                OP_EXEC: begin
                    if (i_state.kill_pending) begin
                        n.halted = 1'b1;
                        n.running_lamp = 1'b0;
                        n.waiting = 1'b0;
                        n.delay_count = '0;
                        n.kill_pending = 1'b0;
                        r.status = ST_HALT;
                    end else if (i_state.waiting) begin
                        r.status = ST_WAIT;
                    end else begin
                        unique case (opc)
                            OPC_HALT, OPC_HALT_ALT: begin
                                n.halted = 1'b1;
                                n.running_lamp = 1'b0;
                                n.waiting = 1'b0;
                                n.delay_count = '0;
                                n.kill_pending = 1'b0;
                                r.status = ST_HALT;
                            end
                            OPC_SHUTDOWN: begin
                                n.shutdown_pointer = {{(ADDR_W-8){1'b0}}, opnd};
                                n.program_pointer = pp_inc;
                            end
                            OPC_DELAY: begin
                                if (i_state.pause_pending) begin
                                    n.pause_pending = 1'b0;
                                    n.program_pointer = i_state.shutdown_pointer;
                                end else if (product == '0) begin
                                    n.delay_count = '0;
                                    n.program_pointer = pp_inc;
                                end else begin
                                    n.delay_count = product;
                                    n.waiting = 1'b1;
                                    r.status = ST_WAIT;
                                end
                            end
                            OPC_PIN_ON, OPC_PIN_OFF, OPC_PIN_TOGGLE: begin
                                if (!pin_ok) begin
                                    r.status = ST_ERR;
                                end else begin
                                    priority if (opc == OPC_PIN_ON) begin
                                        n.pins = i_state.pins | pin_bit;
                                    end else if (opc == OPC_PIN_OFF) begin
                                        n.pins = i_state.pins & ~pin_bit;
                                    end else begin
                                        n.pins = i_state.pins ^ pin_bit;
                                    end
                                    n.program_pointer = pp_inc;
                                end
                            end
                            OPC_TELEMETRY: begin
                                r.telemetry_valid = 1'b1;
                                r.telemetry_pointer = i_state.program_pointer;
                                r.telemetry_shutdown = i_state.shutdown_pointer;
                                n.program_pointer = pp_inc;
                            end
                            OPC_JUMP: begin
                                n.program_pointer = {{(ADDR_W-8){1'b0}}, opnd};
                            end
                            default: begin
                                r.status = ST_ERR;
                            end
                        endcase
                    end
                end
                OP_TICK: begin
                    if (i_state.waiting) begin
                        n.delay_count = count_dec;
                        if (count_dec == '0) begin
                            n.waiting = 1'b0;
                            n.program_pointer = pp_inc;
                        end else begin
                            r.status = ST_WAIT;
                        end
                    end
                end
                OP_KILL: begin
                    if (i_state.waiting) begin
                        n.halted = 1'b1;
                        n.running_lamp = 1'b0;
                        n.waiting = 1'b0;
                        n.delay_count = '0;
                        n.kill_pending = 1'b0;
                        r.status = ST_HALT;
                    end else begin
                        n.kill_pending = 1'b1;
                    end
                end
                OP_PAUSE: begin
                    if (i_state.waiting) begin
                        n.waiting = 1'b0;
                        n.delay_count = '0;
                        n.program_pointer = i_state.shutdown_pointer;
                    end else begin
                        n.pause_pending = 1'b1;
                    end
                end
                default: begin
                    r.status = ST_OK;
                end
            endcase
        end
        r.fetch_address = n.program_pointer;
        r.pin_levels = n.pins;
        r.run_light = n.running_lamp;
    end

    assign o_state  = n;
    assign o_result = r;

endmodule

// ----- hw/rtl/pps_out_stage.sv -----
module pps_out_stage
    import pps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_take,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/pps_checker.sv -----
module pps_checker
    import pps_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [1:0]          o_status,
    input logic [ADDR_W-1:0]   o_fetch_address,
    input logic                o_run_light,
    input logic                o_telemetry_valid,
    input logic [ADDR_W-1:0]   o_telemetry_pointer,
    input logic [ADDR_W-1:0]   o_telemetry_shutdown
);

    a_halt_lamp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_HALT) |-> !o_run_light)
        else $error("halt word with run light on");

    a_wait_lamp_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_WAIT) |-> o_run_light)
        else $error("wait word with run light off");

    a_telemetry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_telemetry_valid |->
            (o_telemetry_pointer == '0) && (o_telemetry_shutdown == '0))
        else $error("telemetry fields set without telemetry");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fetch_address))
        else $error("stalled output word changed");

endmodule

bind pin_program_sequencer pps_checker u_pps_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_ready              (o_ready),
    .o_valid              (o_valid),
    .i_ready              (i_ready),
    .o_status             (o_status),
    .o_fetch_address      (o_fetch_address),
    .o_run_light          (o_run_light),
    .o_telemetry_valid    (o_telemetry_valid),
    .o_telemetry_pointer  (o_telemetry_pointer),
    .o_telemetry_shutdown (o_telemetry_shutdown)
);

// ----- verif/testbench.sv -----
module testbench;
    import pps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned PHASE_WORDS = 135;
    localparam logic [7:0] OPC_UNKNOWN_LO = OPC_JUMP + 8'd1;
    localparam logic [7:0] OPC_UNKNOWN_HI = OPC_HALT_ALT - 8'd1;

    typedef enum int unsigned {
        STOP_KILL_IN_DELAY,
        STOP_KILL_LATCHED,
        STOP_OPC_HALT,
        STOP_OPC_HALT_ALT
    } t_stop_path;

    class seq_shadow;
        logic [SCALE_W-1:0] scale;
        logic [ADDR_W-1:0]  pc;
        logic [ADDR_W-1:0]  shut_ptr;
        t_pins              pins;
        logic [COUNT_W-1:0] ticks_left;
        bit                 waiting;
        bit                 halted;
        bit                 kill_latched;
        bit                 pause_latched;
        bit                 lamp;
        t_result            due_q[$];
        int unsigned        failures;

        function new();
            scale = SCALE_RESET;
            pc = '0;
            shut_ptr = '0;
            pins = '0;
            ticks_left = '0;
            waiting = 1'b0;
            halted = 1'b0;
            kill_latched = 1'b0;
            pause_latched = 1'b0;
            lamp = 1'b1;
            failures = 0;
        endfunction

        function void stop_run();
            halted = 1'b1;
            lamp = 1'b0;
            waiting = 1'b0;
            ticks_left = '0;
            kill_latched = 1'b0;
        endfunction

        function t_result step_result(t_op op, logic [WORD_W-1:0] word);
            t_result r;
            logic [7:0] opc;
            logic [7:0] opnd;
            logic [PIN_IDX_W-1:0] pin;
            r = '0;
            r.status = ST_OK;
            opc = word[15:8];
            opnd = word[7:0];
            pin = opnd[PIN_IDX_W-1:0];
            if (halted) begin
                r.status = ST_HALT;
            end else begin
                case (op)
                    OP_EXEC: begin
                        if (kill_latched) begin
                            stop_run();
                            r.status = ST_HALT;
                        end else if (waiting) begin
                            r.status = ST_WAIT;
                        end else begin
                            case (opc)
                                OPC_HALT, OPC_HALT_ALT: begin
                                    stop_run();
                                    r.status = ST_HALT;
                                end
                                OPC_SHUTDOWN: begin
                                    shut_ptr = ADDR_W'(opnd);
                                    pc++;
                                end
                                OPC_DELAY: begin
                                    if (pause_latched) begin
                                        pause_latched = 1'b0;
                                        pc = shut_ptr;
                                    end else begin
                                        ticks_left = COUNT_W'(opnd) * COUNT_W'(scale);
                                        if (ticks_left == 0) begin
                                            pc++;
                                        end else begin
                                            waiting = 1'b1;
                                            r.status = ST_WAIT;
                                        end
                                    end
                                end
                                OPC_PIN_ON, OPC_PIN_OFF, OPC_PIN_TOGGLE: begin
                                    if (pin >= NUM_PINS) begin
                                        r.status = ST_ERR;
                                    end else begin
                                        if (opc == OPC_PIN_ON)
                                            pins[pin] = 1'b1;
                                        else if (opc == OPC_PIN_OFF)
                                            pins[pin] = 1'b0;
                                        else
                                            pins[pin] = ~pins[pin];
                                        pc++;
                                    end
                                end
                                OPC_TELEMETRY: begin
                                    r.telemetry_valid = 1'b1;
                                    r.telemetry_pointer = pc;
                                    r.telemetry_shutdown = shut_ptr;
                                    pc++;
                                end
                                OPC_JUMP: begin
                                    pc = ADDR_W'(opnd);
                                end
                                default: begin
                                    r.status = ST_ERR;
                                end
                            endcase
                        end
                    end
                    OP_TICK: begin
                        if (waiting) begin
                            ticks_left--;
                            if (ticks_left == 0) begin
                                waiting = 1'b0;
                                pc++;
                            end else begin
                                r.status = ST_WAIT;
                            end
                        end
                    end
                    OP_KILL: begin
                        if (waiting) begin
                            stop_run();
                            r.status = ST_HALT;
                        end else begin
                            kill_latched = 1'b1;
                        end
                    end
                    default: begin
                        if (waiting) begin
                            waiting = 1'b0;
                            ticks_left = '0;
                            pc = shut_ptr;
                        end else begin
                            pause_latched = 1'b1;
                        end
                    end
                endcase
            end
            r.fetch_address = pc;
            r.pin_levels = pins;
            r.run_light = lamp;
            return r;
        endfunction

        function void set_scale(logic [SCALE_W-1:0] value);
            scale = value;
        endfunction

        function void note_word(t_op op, logic [WORD_W-1:0] word);
            due_q.push_back(step_result(op, word));
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result word with nothing due", $time);
                return;
            end
            want = due_q.pop_front();
            if (got.status !== want.status || got.fetch_address !== want.fetch_address ||
                got.pin_levels !== want.pin_levels || got.run_light !== want.run_light ||
                got.telemetry_valid !== want.telemetry_valid ||
                got.telemetry_pointer !== want.telemetry_pointer ||
                got.telemetry_shutdown !== want.telemetry_shutdown) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: mismatch exp st=%0d fa=%h pins=%b run=%b tv=%b tp=%h ts=%h",
                             $time, want.status, want.fetch_address, want.pin_levels,
                             want.run_light, want.telemetry_valid, want.telemetry_pointer,
                             want.telemetry_shutdown);
                    $display("%0t:          got st=%0d fa=%h pins=%b run=%b tv=%b tp=%h ts=%h",
                             $time, got.status, got.fetch_address, got.pin_levels,
                             got.run_light, got.telemetry_valid, got.telemetry_pointer,
                             got.telemetry_shutdown);
                end
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [SCALE_W-1:0]  i_cfg_delay_scale;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_operation;
    logic [WORD_W-1:0]   i_instruction_word;
    logic                o_valid;
    logic                i_ready;
    logic [1:0]          o_status;
    logic [ADDR_W-1:0]   o_fetch_address;
    logic [NUM_PINS-1:0] o_pin_levels;
    logic                o_run_light;
    logic                o_telemetry_valid;
    logic [ADDR_W-1:0]   o_telemetry_pointer;
    logic [ADDR_W-1:0]   o_telemetry_shutdown;

    seq_shadow          shadow;
    int unsigned        cycle_count;
    int unsigned        words_sent;
    int unsigned        in_quiet;
    int unsigned        out_quiet;
    bit                 stream_on;
    logic [SCALE_W-1:0] cur_scale;

    pin_program_sequencer u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_delay_scale    (i_cfg_delay_scale),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_operation          (i_operation),
        .i_instruction_word   (i_instruction_word),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_fetch_address      (o_fetch_address),
        .o_pin_levels         (o_pin_levels),
        .o_run_light          (o_run_light),
        .o_telemetry_valid    (o_telemetry_valid),
        .o_telemetry_pointer  (o_telemetry_pointer),
        .o_telemetry_shutdown (o_telemetry_shutdown)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                shadow.note_word(t_op'(i_operation), i_instruction_word);
            if (o_valid && i_ready) begin
                got.status = t_status'(o_status);
                got.fetch_address = o_fetch_address;
                got.pin_levels = o_pin_levels;
                got.run_light = o_run_light;
                got.telemetry_valid = o_telemetry_valid;
                got.telemetry_pointer = o_telemetry_pointer;
                got.telemetry_shutdown = o_telemetry_shutdown;
                shadow.check_word(got);
            end
        end
    end

    function automatic int unsigned idle_len(inout int unsigned quiet);
        int unsigned r;
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int unsigned r;
        logic [7:0] opnd;
        logic [7:0] opc;
        r = $urandom_range(0, 99);
        opnd = 8'($urandom);
        if (r < 15)
            return {OPC_SHUTDOWN, opnd};
        if (r < 50) begin
            case ($urandom_range(0, 2))
                0: opc = OPC_PIN_ON;
                1: opc = OPC_PIN_OFF;
                default: opc = OPC_PIN_TOGGLE;
            endcase
            if ($urandom_range(0, 4) != 0)
                opnd[PIN_IDX_W-1:0] = PIN_IDX_W'($urandom_range(0, NUM_PINS - 1));
            return {opc, opnd};
        end
        if (r < 62)
            return {OPC_TELEMETRY, opnd};
        if (r < 80)
            return {OPC_JUMP, opnd};
        return {8'($urandom_range(OPC_UNKNOWN_LO, OPC_UNKNOWN_HI)), opnd};
    endfunction

    task automatic send_item(t_op op, logic [WORD_W-1:0] word);
        int unsigned gap;
        gap = idle_len(in_quiet);
        if (gap != 0) begin
            if (stream_on)
                i_valid <= 1'b0;
            stream_on = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_instruction_word <= word;
        stream_on = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic drain();
        if (stream_on)
            i_valid <= 1'b0;
        stream_on = 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_delay_scale <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow.set_scale(value);
        cur_scale = value;
    endtask

    task automatic delay_run();
        int unsigned target;
        int unsigned ticks;
        logic [7:0] opnd;
        logic [COUNT_W-1:0] span;
        bit quit;
        if (cur_scale == 0 || $urandom_range(0, 19) == 0) begin
            opnd = 8'($urandom);
        end else begin
            if ($urandom_range(0, 4) != 0)
                target = $urandom_range(1, 40);
            else
                target = $urandom_range(41, 300);
            target = target / cur_scale;
            opnd = (target > 255) ? 8'hFF : 8'(target);
            if (opnd == 0)
                opnd = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'd1;
        end
        span = COUNT_W'(opnd) * COUNT_W'(cur_scale);
        quit = (span > 400) || ($urandom_range(0, 3) == 0);
        ticks = (span > 400) ? $urandom_range(1, 30) : span;
        if (quit)
            ticks = $urandom_range(0, ticks);
        send_item(OP_EXEC, {OPC_DELAY, opnd});
        repeat (ticks) begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_EXEC, rand_word());
            send_item(OP_TICK, WORD_W'($urandom));
        end
        if (quit)
            send_item(OP_PAUSE, WORD_W'($urandom));
    endtask

    task automatic random_action();
        int unsigned r;
        logic [WORD_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            send_item(OP_EXEC, rand_word());
        end else if (r < 80) begin
            delay_run();
        end else if (r < 88) begin
            send_item(OP_PAUSE, WORD_W'($urandom));
        end else if (r < 95) begin
            send_item(OP_TICK, WORD_W'($urandom));
        end else begin
            w = WORD_W'($urandom);
            if (w[15:8] == OPC_HALT || w[15:8] == OPC_HALT_ALT)
                w[15:8] = OPC_TELEMETRY;
            send_item(OP_EXEC, w);
        end
    endtask

    task automatic directed_words();
        send_item(OP_EXEC, {OPC_SHUTDOWN, 8'hFF});
        send_item(OP_EXEC, {OPC_PIN_ON, 8'h00});
        send_item(OP_EXEC, {OPC_PIN_ON, 8'hE2});
        send_item(OP_EXEC, {OPC_PIN_TOGGLE, 8'h01});
        send_item(OP_EXEC, {OPC_PIN_OFF, 8'h00});
        send_item(OP_EXEC, {OPC_PIN_ON, 8'h03});
        send_item(OP_EXEC, {OPC_PIN_TOGGLE, 8'h1F});
        send_item(OP_EXEC, {OPC_TELEMETRY, 8'hA5});
        send_item(OP_EXEC, {OPC_UNKNOWN_LO, 8'h00});
        send_item(OP_EXEC, {OPC_UNKNOWN_HI, 8'hFF});
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_EXEC, {OPC_JUMP, 8'hFF});
        send_item(OP_EXEC, {OPC_TELEMETRY, 8'h00});
        send_item(OP_PAUSE, 16'h0000);
        send_item(OP_EXEC, {OPC_DELAY, 8'h05});
        send_item(OP_EXEC, {OPC_DELAY, 8'h00});
        send_item(OP_EXEC, {OPC_DELAY, 8'h01});
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h5A5A);
        send_item(OP_PAUSE, 16'hFFFF);
        send_item(OP_EXEC, {OPC_SHUTDOWN, 8'h00});
    endtask

    task automatic wind_down();
        t_stop_path path;
        drain();
        write_scale(SCALE_RESET);
        // force a running delay whatever state the random part left behind
        send_item(OP_PAUSE, WORD_W'($urandom));
        send_item(OP_EXEC, {OPC_DELAY, 8'h01});
        send_item(OP_EXEC, {OPC_DELAY, 8'h01});
        path = t_stop_path'($urandom_range(0, 3));
        case (path)
            STOP_KILL_IN_DELAY: begin
                send_item(OP_KILL, WORD_W'($urandom));
            end
            STOP_KILL_LATCHED: begin
                send_item(OP_PAUSE, WORD_W'($urandom));
                send_item(OP_KILL, WORD_W'($urandom));
                send_item(OP_PAUSE, WORD_W'($urandom));
                send_item(OP_TICK, WORD_W'($urandom));
                send_item(OP_EXEC, rand_word());
            end
            STOP_OPC_HALT: begin
                send_item(OP_PAUSE, WORD_W'($urandom));
                send_item(OP_EXEC, {OPC_HALT, 8'($urandom)});
            end
            default: begin
                send_item(OP_PAUSE, WORD_W'($urandom));
                send_item(OP_EXEC, {OPC_HALT_ALT, 8'($urandom)});
            end
        endcase
        repeat (20) send_item(t_op'($urandom_range(0, 3)), WORD_W'($urandom));
    endtask

    initial begin : sink
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            stall = idle_len(out_quiet);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [SCALE_W-1:0] scales [7];
        int unsigned goal;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_EXEC;
        i_instruction_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_delay_scale = SCALE_RESET;
        i_ready = 1'b0;
        cycle_count = 0;
        words_sent = 0;
        in_quiet = 0;
        out_quiet = 0;
        stream_on = 1'b0;
        cur_scale = SCALE_RESET;
        shadow = new();
        scales = '{SCALE_RESET, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd37, 10'd500};
        scales[6] = SCALE_W'($urandom_range(1, 1000));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_words();
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                drain();
                write_scale(scales[p]);
            end
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
                random_action();
        end
        wind_down();
        drain();
        repeat (4) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
